### hdl/col_pkg.sv
`timescale 1ns / 1ps

package col_pkg;

  // List geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 64;
  localparam int POS_W    = 6;
  localparam int KIND_W   = 4;
  localparam int STAT_W   = 2;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Gather tree: groups of cells ORed in the first stage
  localparam int GRP      = 8;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

  // Stream payload widths
  localparam int IN_DATA_W  = ((WORD_W + POS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * WORD_W + 1 + CNT_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    K_START     = 4'd0,
    K_ADVANCE   = 4'd1,
    K_INSERT    = 4'd2,
    K_ATTACH    = 4'd3,
    K_REMOVE    = 4'd4,
    K_ADD_FRONT = 4'd5,
    K_REM_FRONT = 4'd6,
    K_ADD_END   = 4'd7,
    K_LAST      = 4'd8,
    K_READ      = 4'd9
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Cell row operation: open a gap at an index, or close the gap at one
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_GATHER = 2'd1,
    S_MERGE  = 2'd2
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  at;
    logic [WORD_W-1:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic             cur_en;
    logic [CNT_W-1:0] cur_idx;
    logic             rd_en;
    logic [CNT_W-1:0] rd_idx;
  } cell_sel_t;

endpackage

### hdl/col_cell.sv
`timescale 1ns / 1ps

module col_cell (
  input  logic                       clk,
  input  logic [col_pkg::IDX_W-1:0]  idx,
  input  col_pkg::cell_ctl_t         ctl,
  input  col_pkg::cell_sel_t         sel,
  input  logic [col_pkg::WORD_W-1:0] lower,
  input  logic [col_pkg::WORD_W-1:0] upper,
  output logic [col_pkg::WORD_W-1:0] word,
  output logic [col_pkg::WORD_W-1:0] cur_word,
  output logic [col_pkg::WORD_W-1:0] rd_word
);
  import col_pkg::*;

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  // Take the neighbor below when a gap opens (the cell at the index takes the new word), the one above when it closes
  always_comb begin
    word_nxt = word_r;
    case (ctl.op)
      OP_OPEN: begin
        if (idx > ctl.at) begin
          word_nxt = lower;
        end else if (idx == ctl.at) begin
          word_nxt = ctl.value;
        end
      end
      OP_CLOSE: begin
        if (idx >= ctl.at) begin
          word_nxt = upper;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // Drive the word onto the gather lines only when selected
  assign word     = word_r;
  assign cur_word = (sel.cur_en && (CNT_W'(idx) == sel.cur_idx)) ? word_r : '0;
  assign rd_word  = (sel.rd_en && (CNT_W'(idx) == sel.rd_idx)) ? word_r : '0;

endmodule

### hdl/col_gather.sv
`timescale 1ns / 1ps

module col_gather (
  input  logic                       clk,
  input  logic [col_pkg::WORD_W-1:0] cur_word [col_pkg::CAPACITY],
  input  logic [col_pkg::WORD_W-1:0] rd_word  [col_pkg::CAPACITY],
  output logic [col_pkg::WORD_W-1:0] cur_out,
  output logic [col_pkg::WORD_W-1:0] rd_out
);
  import col_pkg::*;

  logic [WORD_W-1:0] grp_cur_r   [NGRP];
  logic [WORD_W-1:0] grp_rd_r    [NGRP];
  logic [WORD_W-1:0] grp_cur_nxt [NGRP];
  logic [WORD_W-1:0] grp_rd_nxt  [NGRP];

  // First level: OR each group of cells, then register
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_cur_nxt[g] = '0;
      grp_rd_nxt[g]  = '0;
      for (int m = 0; m < GRP; m++) begin
        if (g * GRP + m < CAPACITY) begin
          grp_cur_nxt[g] = grp_cur_nxt[g] | cur_word[g * GRP + m];
          grp_rd_nxt[g]  = grp_rd_nxt[g]  | rd_word[g * GRP + m];
        end
      end
    end

    always_ff @(posedge clk) begin
      grp_cur_r[g] <= grp_cur_nxt[g];
      grp_rd_r[g]  <= grp_rd_nxt[g];
    end
  end

  // Second level: OR the group results
  always_comb begin
    cur_out = '0;
    rd_out  = '0;
    for (int g = 0; g < NGRP; g++) begin
      cur_out = cur_out | grp_cur_r[g];
      rd_out  = rd_out  | grp_rd_r[g];
    end
  end

endmodule

### hdl/cursor_ordered_list.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY 64-bit words with a cursor, held in a row of
// cells. Each cell holds one entry; an insertion opens a gap by having every
// cell above the index take its lower neighbor's word while the cell at the
// index takes the new word, and a removal closes it by having every cell at
// or above the index take its upper neighbor's, so any command updates the
// whole row in the cycle it is accepted. One result follows each request: the
// row is updated at the accept edge, the selected entries go through a
// two-level OR over the cells, first level registered, and the result is
// loaded into the output register. A command is accepted only once the
// last result is in the output register, which frees the input side, so
// the next request is taken while a result still waits. The store needs no
// clearing after reset: only entries below the count are ever read.
module cursor_ordered_list (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [63:0] value, [69:64] position
  input  logic [col_pkg::IN_DATA_W-1:0]  in_tdata,
  // [3:0] kind
  input  logic [col_pkg::KIND_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [63:0] current_value, [64] has_current, [71:65] count, [135:72] read_value
  output logic [col_pkg::OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [col_pkg::STAT_W-1:0]     out_tuser
);
  import col_pkg::*;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     cursor_r, cursor_nxt;
  status_t              status_r, status_nxt;
  logic                 rd_en_r, rd_en_nxt;
  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  status_t              out_stat_r, out_stat_nxt;

  logic                 in_acc;
  logic                 out_load;
  kind_t                kind;
  logic [WORD_W-1:0]    in_value;
  logic [POS_W-1:0]     in_pos;
  logic                 has_cur;
  logic                 full;
  logic                 rd_ok;
  logic                 cur_valid;
  cell_ctl_t            ctl;
  cell_sel_t            sel;

  logic [WORD_W-1:0]    words     [CAPACITY];
  logic [WORD_W-1:0]    cur_words [CAPACITY];
  logic [WORD_W-1:0]    rd_words  [CAPACITY];
  logic [WORD_W-1:0]    cur_gath;
  logic [WORD_W-1:0]    rd_gath;

  // Unpack the request
  assign kind     = kind_t'(in_tuser);
  assign in_value = in_tdata[WORD_W-1:0];
  assign in_pos   = in_tdata[WORD_W +: POS_W];
  assign in_acc   = in_tvalid && in_tready;

  assign has_cur  = cursor_r < count_r;
  assign full     = count_r == CNT_W'(CAPACITY);
  assign rd_ok    = CMP_W'(in_pos) < CMP_W'(count_r);

  // Decode the command into a row operation, new count and cursor, status and read select
  always_comb begin
    ctl.op     = OP_HOLD;
    ctl.at     = '0;
    ctl.value  = in_value;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    status_nxt = status_r;
    rd_en_nxt  = rd_en_r;
    rd_idx_nxt = rd_idx_r;
    if (in_acc) begin
      status_nxt = ST_OK;
      rd_en_nxt  = 1'b0;
      rd_idx_nxt = CNT_W'(in_pos);
      unique case (kind)
        K_START: cursor_nxt = '0;
        K_ADVANCE: begin
          if (has_cur) begin
            cursor_nxt = cursor_r + 1'b1;
          end
        end
        K_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.op     = OP_OPEN;
            ctl.at     = has_cur ? cursor_r[IDX_W-1:0] : '0;
            cursor_nxt = has_cur ? cursor_r : '0;
            count_nxt  = count_r + 1'b1;
          end
        end
        K_ATTACH: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.op     = OP_OPEN;
            cursor_nxt = has_cur ? cursor_r + 1'b1 : count_r;
            ctl.at     = has_cur ? IDX_W'(cursor_r + 1'b1) : count_r[IDX_W-1:0];
            count_nxt  = count_r + 1'b1;
          end
        end
        K_REMOVE: begin
          if (!has_cur) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctl.op    = OP_CLOSE;
            ctl.at    = cursor_r[IDX_W-1:0];
            count_nxt = count_r - 1'b1;
          end
        end
        K_ADD_FRONT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.op     = OP_OPEN;
            cursor_nxt = '0;
            count_nxt  = count_r + 1'b1;
          end
        end
        K_REM_FRONT: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctl.op     = OP_CLOSE;
            cursor_nxt = '0;
            count_nxt  = count_r - 1'b1;
          end
        end
        K_ADD_END: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.op     = OP_OPEN;
            ctl.at     = count_r[IDX_W-1:0];
            cursor_nxt = count_r;
            count_nxt  = count_r + 1'b1;
          end
        end
        K_LAST: cursor_nxt = (count_r != '0) ? count_r - 1'b1 : '0;
        K_READ: begin
          rd_en_nxt = rd_ok;
          if (!rd_ok) begin
            status_nxt = ST_RANGE;
          end
        end
        default: ;
      endcase
    end
  end

  // Select the cursor entry and the read entry from the updated row
  assign cur_valid  = has_cur;
  assign sel.cur_en  = cur_valid;
  assign sel.cur_idx = cursor_r;
  assign sel.rd_en   = rd_en_r;
  assign sel.rd_idx  = rd_idx_r;

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    col_cell u_cell (
      .clk      (clk),
      .idx      (IDX_W'(i)),
      .ctl      (ctl),
      .sel      (sel),
      .lower    ((i == 0) ? '0 : words[(i == 0) ? 0 : i - 1]),
      .upper    ((i == CAPACITY - 1) ? '0 : words[(i == CAPACITY - 1) ? i : i + 1]),
      .word     (words[i]),
      .cur_word (cur_words[i]),
      .rd_word  (rd_words[i])
    );
  end

  col_gather u_gather (
    .clk      (clk),
    .cur_word (cur_words),
    .rd_word  (rd_words),
    .cur_out  (cur_gath),
    .rd_out   (rd_gath)
  );

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_GATHER;
      S_GATHER: state_nxt = S_MERGE;
      S_MERGE:  if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE:   in_tready = 1'b1;
      S_GATHER: ;
      S_MERGE:  out_load = !out_valid_r || out_tready;
      default:  ;
    endcase
  end

  // Output register
  always_comb begin
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_stat_nxt  = status_r;
      out_data_nxt  = OUT_DATA_W'({rd_gath, count_r, cur_valid, cur_gath});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
      rd_en_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
      rd_en_r     <= rd_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  // Checks
  a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r)
    else $error("cursor beyond count");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  a_accept_gather: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_GATHER)
    else $error("accepted request did not start gather");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE && status_r == ST_FULL) |-> full)
    else $error("full status with room left");

endmodule

### test/list_result_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels of the cursor list, keeps its own copy of the
// list, the count and the cursor, and compares every result with the oldest
// prediction still waiting.
module list_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // [63:0] value, [69:64] position
  input  logic [col_pkg::IN_DATA_W-1:0]  in_tdata,
  // [3:0] kind
  input  logic [col_pkg::KIND_W-1:0]     in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // [63:0] current_value, [64] has_current, [71:65] count, [135:72] read_value
  input  logic [col_pkg::OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  input  logic [col_pkg::STAT_W-1:0]     out_tuser,
  output int                             fail_count,
  output int                             pending_results
);
  import col_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] cur_word;
    logic              has_cur;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] read_word;
  } list_result_t;

  // Shadow copy of the list
  logic [WORD_W-1:0] list_words [CAPACITY];
  int n_words = 0;
  int cur_idx = 0;

  list_result_t expected_results [$];
  int mismatches = 0;
  int results_seen = 0;

  initial begin
    fail_count = 0;
    pending_results = 0;
  end

  // Shift entries at and above an index up one place
  function automatic void open_gap(input int at);
    int i;
    for (i = n_words; i > at; i--) list_words[i] = list_words[i - 1];
  endfunction

  // Shift entries above an index down one place
  function automatic void close_gap(input int at);
    int i;
    for (i = at; i + 1 < n_words; i++) list_words[i] = list_words[i + 1];
  endfunction

  // Apply one request to the shadow list and return the result it must give
  function automatic list_result_t apply_list_cmd(input logic [KIND_W-1:0] kind,
                                                  input logic [WORD_W-1:0] word,
                                                  input logic [POS_W-1:0]  pos);
    list_result_t r;
    bit had_cur;
    bit full;
    r = '0;
    had_cur = cur_idx < n_words;
    full = n_words >= CAPACITY;
    case (kind)
      K_START: cur_idx = 0;
      K_ADVANCE: if (had_cur) cur_idx++;
      K_INSERT: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          // no current entry: the word goes to the front
          if (!had_cur) cur_idx = 0;
          open_gap(cur_idx);
          list_words[cur_idx] = word;
          n_words++;
        end
      end
      K_ATTACH: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          // no current entry: the word goes to the end
          if (had_cur) begin
            open_gap(cur_idx + 1);
            cur_idx++;
          end else begin
            cur_idx = n_words;
          end
          list_words[cur_idx] = word;
          n_words++;
        end
      end
      K_REMOVE: begin
        if (!had_cur) begin
          r.status = ST_EMPTY;
        end else begin
          close_gap(cur_idx);
          n_words--;
        end
      end
      K_ADD_FRONT: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          open_gap(0);
          list_words[0] = word;
          n_words++;
          cur_idx = 0;
        end
      end
      K_REM_FRONT: begin
        if (n_words == 0) begin
          r.status = ST_EMPTY;
        end else begin
          close_gap(0);
          n_words--;
          cur_idx = 0;
        end
      end
      K_ADD_END: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          list_words[n_words] = word;
          cur_idx = n_words;
          n_words++;
        end
      end
      K_LAST: cur_idx = (n_words > 0) ? n_words - 1 : 0;
      K_READ: begin
        if (pos < n_words) r.read_word = list_words[pos];
        else r.status = ST_RANGE;
      end
      default: ;
    endcase
    r.has_cur = cur_idx < n_words;
    r.cur_word = r.has_cur ? list_words[cur_idx] : '0;
    r.count = n_words[CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    mismatches++;
    $display("%0t: result %0d %s: got %h, expected %h", $time, results_seen, what,
             got, want);
  endtask

  // Check results first, then log the new request, so a result never meets
  // a prediction made at the same edge
  always @(posedge clk) begin : watch_channels
    list_result_t want;
    if (!rst_n) begin
      expected_results.delete();
      n_words = 0;
      cur_idx = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[WORD_W-1:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.status)
            report_mismatch("status", WORD_W'(out_tuser), WORD_W'(want.status));
          if (out_tdata[WORD_W-1:0] !== want.cur_word)
            report_mismatch("current_value", out_tdata[WORD_W-1:0], want.cur_word);
          if (out_tdata[WORD_W] !== want.has_cur)
            report_mismatch("has_current", WORD_W'(out_tdata[WORD_W]),
                            WORD_W'(want.has_cur));
          if (out_tdata[WORD_W+CNT_W:WORD_W+1] !== want.count)
            report_mismatch("count", WORD_W'(out_tdata[WORD_W+CNT_W:WORD_W+1]),
                            WORD_W'(want.count));
          if (out_tdata[2*WORD_W+CNT_W:WORD_W+CNT_W+1] !== want.read_word)
            report_mismatch("read_value", out_tdata[2*WORD_W+CNT_W:WORD_W+CNT_W+1],
                            want.read_word);
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_list_cmd(in_tuser, in_tdata[WORD_W-1:0],
                                                  in_tdata[WORD_W+POS_W-1:WORD_W]));
    end
    pending_results <= expected_results.size();
    fail_count <= mismatches;
  end

endmodule

### test/tb_cursor_ordered_list.sv
`timescale 1ns / 1ps

module tb_cursor_ordered_list;
  import col_pkg::*;

  localparam int RANDOM_ITEMS = 1875;
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 12;
  // Kinds with no meaning: the block must leave the list alone
  localparam logic [KIND_W-1:0] K_UNUSED_LO = 4'd10;
  localparam logic [KIND_W-1:0] K_UNUSED_HI = 4'd15;

  typedef enum logic [1:0] {
    MIX_FILL  = 2'd0,
    MIX_DRAIN = 2'd1,
    MIX_ANY   = 2'd2
  } cmd_mix_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;
  int                    fail_count;
  int                    pending_results;
  int                    burst_left = 0;

  always #6 clk = ~clk;

  cursor_ordered_list uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  list_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Offer one request, hold it until taken, then keep the burst going or gap
  task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] word,
                          input logic [POS_W-1:0] pos);
    logic [IN_DATA_W-1:0] payload;
    int gap;
    payload = '0;
    payload[WORD_W-1:0] = word;
    payload[WORD_W+POS_W-1:WORD_W] = pos;
    in_tdata  <= payload;
    in_tuser  <= kind;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(0, 12);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stimulus
  initial begin : stimulus
    int n;
    int phase_no;
    int phase_left;
    int roll;
    cmd_mix_t mix;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word;
    logic [POS_W-1:0] pos;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list corners
    send_cmd(K_START, '0, '0);
    send_cmd(K_ADVANCE, '0, '0);
    send_cmd(K_REMOVE, '0, '0);
    send_cmd(K_REM_FRONT, '0, '0);
    send_cmd(K_LAST, '0, '0);
    send_cmd(K_READ, '0, '0);
    // Insert with no current entry lands at the front
    send_cmd(K_INSERT, {WORD_W{1'b1}}, {POS_W{1'b1}});
    send_cmd(K_ADVANCE, '0, '0);
    send_cmd(K_INSERT, '0, '0);
    send_cmd(K_ATTACH, 64'h0123_4567_89ab_cdef, '0);
    // Walk off the end, then attach with no current entry
    send_cmd(K_LAST, '0, '0);
    send_cmd(K_ADVANCE, '0, '0);
    send_cmd(K_ATTACH, 64'ha5a5_5a5a_a5a5_5a5a, '0);
    send_cmd(K_ADD_FRONT, 64'h8000_0000_0000_0001, '0);
    send_cmd(K_ADD_END, 64'h7fff_ffff_ffff_fffe, '0);
    // Reads inside and past the count
    send_cmd(K_READ, '0, 6'd0);
    send_cmd(K_READ, '0, 6'd5);
    send_cmd(K_READ, '0, 6'd6);
    send_cmd(K_READ, '0, {POS_W{1'b1}});
    // Removals: at the front, at the last entry, and with nothing current
    send_cmd(K_START, '0, '0);
    send_cmd(K_REMOVE, '0, '0);
    send_cmd(K_LAST, '0, '0);
    send_cmd(K_REMOVE, '0, '0);
    send_cmd(K_REMOVE, '0, '0);
    send_cmd(K_REM_FRONT, '0, '0);
    send_cmd(K_UNUSED_LO, {WORD_W{1'b1}}, {POS_W{1'b1}});
    send_cmd(K_UNUSED_HI, {WORD_W{1'b1}}, {POS_W{1'b1}});

    // Random part: fill toward full, mix, drain toward empty, mix, and again
    phase_no = 0;
    phase_left = 0;
    mix = MIX_FILL;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        case (phase_no % 4)
          0: mix = MIX_FILL;
          2: mix = MIX_DRAIN;
          default: mix = MIX_ANY;
        endcase
        phase_left = (mix == MIX_ANY) ? $urandom_range(40, 120) : $urandom_range(110, 180);
        phase_no++;
      end
      phase_left--;

      roll = $urandom_range(0, 99);
      kind = KIND_W'($urandom_range(0, 15));
      if (mix == MIX_FILL && roll < 75) begin
        case ($urandom_range(0, 3))
          0: kind = K_INSERT;
          1: kind = K_ATTACH;
          2: kind = K_ADD_FRONT;
          default: kind = K_ADD_END;
        endcase
      end else if (mix == MIX_DRAIN && roll < 60) begin
        kind = ($urandom_range(0, 1) == 0) ? K_REMOVE : K_REM_FRONT;
      end else if (roll < 85) begin
        case ($urandom_range(0, 4))
          0: kind = K_START;
          1: kind = K_ADVANCE;
          2: kind = K_LAST;
          default: kind = K_READ;
        endcase
      end

      case ($urandom_range(0, 9))
        0: word = '0;
        1: word = {WORD_W{1'b1}};
        default: word = {$urandom, $urandom};
      endcase
      pos = POS_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                               : $urandom_range(0, 63));
      send_cmd(kind, word, pos);
    end

    // Drain outstanding results, then let the pipeline settle
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver pacing: random stretches of ready, choppy and mostly stalled,
  // plus one long hold-off that backs the block up into its input
  initial begin : rx_pacing
    int seg;
    int len;
    int mode;
    int c;
    seg = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (seg == 6) begin
        out_tready <= 1'b0;
        for (c = 0; c < LONG_HOLD; c++) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        len = $urandom_range(20, 120);
        for (c = 0; c < len; c++) begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= 1'($urandom_range(0, 1));
            default: out_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
      seg++;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
hdl/col_pkg.sv
hdl/col_cell.sv
hdl/col_gather.sv
hdl/cursor_ordered_list.sv
test/list_result_checker.sv
test/tb_cursor_ordered_list.sv
